FILE: design/rbi_pkg.sv
// Shared types and constants for the rectilinear bilinear interpolator.
// Used by the controller, the datapath and the top level. No dependencies.
package rbi_pkg;

   localparam int WORD_BITS        = 32;
   localparam int DEF_MAX_X_POINTS = 256;
   localparam int DEF_MAX_Z_POINTS = 256;
   localparam int DIV_STEPS        = WORD_BITS + 1;
   localparam int DIV_CNT_BITS     = $clog2(DIV_STEPS);

   // request commands
   localparam logic [1:0] CMD_LOAD_X    = 2'd0;
   localparam logic [1:0] CMD_LOAD_Z    = 2'd1;
   localparam logic [1:0] CMD_LOAD_GRID = 2'd2;
   localparam logic [1:0] CMD_QUERY     = 2'd3;

   // result status codes
   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_BOUNDS  = 2'd1;
   localparam logic [1:0] STS_SPACING = 2'd2;
   localparam logic [1:0] STS_LOADED  = 2'd3;

   // datapath operations
   localparam logic [3:0] OP_NONE     = 4'd0;
   localparam logic [3:0] OP_ACCEPT   = 4'd1;
   localparam logic [3:0] OP_LOAD     = 4'd2;
   localparam logic [3:0] OP_SINIT    = 4'd3;
   localparam logic [3:0] OP_SREAD    = 4'd4;
   localparam logic [3:0] OP_SCMP     = 4'd5;
   localparam logic [3:0] OP_BOUND    = 4'd6;
   localparam logic [3:0] OP_FETCH    = 4'd7;
   localparam logic [3:0] OP_CHECK    = 4'd8;
   localparam logic [3:0] OP_TERM_P   = 4'd9;
   localparam logic [3:0] OP_TERM_LO  = 4'd10;
   localparam logic [3:0] OP_TERM_HI  = 4'd11;
   localparam logic [3:0] OP_DIV_INIT = 4'd12;
   localparam logic [3:0] OP_DIV_STEP = 4'd13;

   localparam logic REG_X_POINTS = 1'b0;
   localparam logic REG_Z_POINTS = 1'b1;

   typedef struct packed {
      logic [1:0]                  command;
      logic [7:0]                  row_index;
      logic [7:0]                  column_index;
      logic signed [WORD_BITS-1:0] load_word;
      logic signed [WORD_BITS-1:0] query_x;
      logic signed [WORD_BITS-1:0] query_z;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] interp_value;
      logic [1:0]                  status;
      logic                        saturated;
   } rsp_type;

   typedef struct packed {
      logic [3:0] op;
      logic       axis;
      logic [2:0] step;
      logic [1:0] term;
      logic       emit;
      logic [1:0] emit_status;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_query;
      logic search_empty;
      logic out_of_bounds;
      logic zero_spacing;
   } dp_status_type;

endpackage

FILE: design/rbi_controller.sv
// Sequencer for the interpolator: decodes requests and steps the datapath
// through search, fetch, blend and divide. Depends on rbi_pkg.
module rbi_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output rbi_pkg::ctl_cmd_type  cmd,
   input  rbi_pkg::dp_status_type st
);
   import rbi_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_SRD      = 4'd2;
   localparam logic [3:0] S_SCMP     = 4'd3;
   localparam logic [3:0] S_BOUND    = 4'd4;
   localparam logic [3:0] S_FETCH    = 4'd5;
   localparam logic [3:0] S_CHECK    = 4'd6;
   localparam logic [3:0] S_TP       = 4'd7;
   localparam logic [3:0] S_TLO      = 4'd8;
   localparam logic [3:0] S_THI      = 4'd9;
   localparam logic [3:0] S_DIV_INIT = 4'd10;
   localparam logic [3:0] S_DIV      = 4'd11;
   localparam logic [3:0] S_DONE     = 4'd12;

   logic [3:0]              state_ff, state_in;
   logic                    axis_ff, axis_in;
   logic [2:0]              step_ff, step_in;
   logic [1:0]              term_ff, term_in;
   logic [DIV_CNT_BITS-1:0] div_cnt_ff, div_cnt_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in   = state_ff;
      axis_in    = axis_ff;
      step_in    = step_ff;
      term_in    = term_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      cmd.op     = OP_NONE;
      cmd.axis   = axis_ff;
      cmd.step   = step_ff;
      cmd.term   = term_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = OP_ACCEPT;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (st.is_query) begin
               cmd.op   = OP_SINIT;
               cmd.axis = 1'b0;
               axis_in  = 1'b0;
               state_in = S_SRD;
            end else begin
               cmd.op          = OP_LOAD;
               cmd.emit        = 1'b1;
               cmd.emit_status = STS_LOADED;
               state_in        = S_IDLE;
            end
         end
         S_SRD: begin
            if (st.search_empty) begin
               if (!axis_ff) begin
                  // x search done, start z
                  cmd.op   = OP_SINIT;
                  cmd.axis = 1'b1;
                  axis_in  = 1'b1;
               end else begin
                  state_in = S_BOUND;
               end
            end else begin
               cmd.op   = OP_SREAD;
               state_in = S_SCMP;
            end
         end
         S_SCMP: begin
            cmd.op   = OP_SCMP;
            state_in = S_SRD;
         end
         S_BOUND: begin
            cmd.op = OP_BOUND;
            if (st.out_of_bounds) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = STS_BOUNDS;
               state_in        = S_IDLE;
            end else begin
               step_in  = 3'd0;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            cmd.op  = OP_FETCH;
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd4) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (st.zero_spacing) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = STS_SPACING;
               state_in        = S_IDLE;
            end else begin
               cmd.op   = OP_CHECK;
               term_in  = 2'd0;
               state_in = S_TP;
            end
         end
         S_TP: begin
            cmd.op   = OP_TERM_P;
            state_in = S_TLO;
         end
         S_TLO: begin
            cmd.op   = OP_TERM_LO;
            state_in = S_THI;
         end
         S_THI: begin
            cmd.op  = OP_TERM_HI;
            term_in = term_ff + 2'd1;
            if (term_ff == 2'd3) begin
               state_in = S_DIV_INIT;
            end else begin
               state_in = S_TP;
            end
         end
         S_DIV_INIT: begin
            cmd.op     = OP_DIV_INIT;
            div_cnt_in = '0;
            state_in   = S_DIV;
         end
         S_DIV: begin
            cmd.op     = OP_DIV_STEP;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            cmd.emit        = 1'b1;
            cmd.emit_status = STS_OK;
            state_in        = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         axis_ff    <= 1'b0;
         step_ff    <= '0;
         term_ff    <= '0;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         axis_ff    <= axis_in;
         step_ff    <= step_in;
         term_ff    <= term_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

endmodule

FILE: design/rbi_datapath.sv
// Datapath: coordinate and grid memories, lower-bound search, corner fetch,
// exact blend with shared multipliers and a restoring divider. Uses rbi_pkg.
module rbi_datapath #(
   parameter int MAX_X_POINTS = rbi_pkg::DEF_MAX_X_POINTS,
   parameter int MAX_Z_POINTS = rbi_pkg::DEF_MAX_Z_POINTS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rbi_pkg::req_type       req_payload,
   input  logic [8:0]             x_points,
   input  logic [8:0]             z_points,
   input  rbi_pkg::ctl_cmd_type   cmd,
   output rbi_pkg::dp_status_type st,
   output logic                   rsp_valid,
   output rbi_pkg::rsp_type       rsp_payload
);
   import rbi_pkg::*;

   localparam int W     = WORD_BITS;
   localparam int D     = W + 1;
   localparam int P     = 2 * D;
   localparam int NUM   = 3 * W + 3;
   localparam int MAX_N = (MAX_X_POINTS > MAX_Z_POINTS) ? MAX_X_POINTS : MAX_Z_POINTS;
   localparam int SW    = $clog2(MAX_N + 1);
   localparam int XA    = $clog2(MAX_X_POINTS);
   localparam int ZA    = $clog2(MAX_Z_POINTS);
   localparam int GA    = $clog2(MAX_X_POINTS * MAX_Z_POINTS);

   req_type req_ff;

   logic signed [W-1:0] x_mem [MAX_X_POINTS];
   logic signed [W-1:0] z_mem [MAX_Z_POINTS];
   logic signed [W-1:0] g_mem [MAX_X_POINTS * MAX_Z_POINTS];
   logic signed [W-1:0] x_rd_ff, z_rd_ff, g_rd_ff;

   logic [SW-1:0] nx, nz;
   logic [SW-1:0] first_ff, count_ff, it_ff, ix_ff;
   logic [SW-1:0] half, it;
   logic [SW-1:0] i1_ff, i2_ff, j1_ff, j2_ff;
   logic [SW-1:0] b_i1, b_i2, b_j1, b_j2, b_iz;

   logic signed [W-1:0] x1_ff, x2_ff, z1_ff, z2_ff;
   logic signed [W-1:0] gv_ff [4];
   logic [2:0]          step_m1;

   logic [P-1:0]   p_ff, den_ff, m1_out;
   logic [D-1:0]   m1_a, m1_b, m2_a;
   logic [W-1:0]   mq_ff, m2_b;
   logic [D+W-1:0] m2_out;
   logic           term_neg_ff, den_neg_ff;
   logic signed [NUM-1:0] acc_ff;
   logic [NUM-1:0] addend, num_mag;
   logic [NUM-D-1:0] num_hi;

   logic [P-1:0] rem_ff;
   logic [D-1:0] num_lo_ff, quo_ff;
   logic         big_ff, neg_ff;
   logic [P:0]   rem_sh;

   logic signed [D-1:0] dx, dz, cw, ch;
   logic [D-1:0] mx, mz, mcw, mch, limit, qval, res;
   logic signed [W-1:0] qsel;
   logic [W-1:0] mqsel;
   logic         sat;

   logic [31:0] row32, col32, gw_lin, gr_lin;
   logic [SW-1:0] gi, gj;
   logic          x_we, z_we, g_we;
   logic [XA-1:0] x_raddr;
   logic [ZA-1:0] z_raddr;

   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff;

   always_comb begin
      if (32'(x_points) > 32'(MAX_X_POINTS)) nx = SW'(MAX_X_POINTS);
      else                                   nx = SW'(x_points);
      if (32'(z_points) > 32'(MAX_Z_POINTS)) nz = SW'(MAX_Z_POINTS);
      else                                   nz = SW'(z_points);
   end

   // load decode
   assign row32  = 32'(req_ff.row_index);
   assign col32  = 32'(req_ff.column_index);
   assign gw_lin = row32 * 32'(MAX_Z_POINTS) + col32;
   assign x_we   = (cmd.op == OP_LOAD) && (req_ff.command == CMD_LOAD_X)
                   && (row32 < 32'(MAX_X_POINTS));
   assign z_we   = (cmd.op == OP_LOAD) && (req_ff.command == CMD_LOAD_Z)
                   && (col32 < 32'(MAX_Z_POINTS));
   assign g_we   = (cmd.op == OP_LOAD) && (req_ff.command == CMD_LOAD_GRID)
                   && (row32 < 32'(MAX_X_POINTS)) && (col32 < 32'(MAX_Z_POINTS));

   // search probe
   assign half = count_ff >> 1;
   assign it   = first_ff + half;

   // read addresses
   always_comb begin
      if (cmd.op == OP_SREAD) begin
         x_raddr = it[XA-1:0];
         z_raddr = it[ZA-1:0];
      end else if (cmd.step == 3'd0) begin
         x_raddr = i1_ff[XA-1:0];
         z_raddr = j1_ff[ZA-1:0];
      end else begin
         x_raddr = i2_ff[XA-1:0];
         z_raddr = j2_ff[ZA-1:0];
      end
   end
   assign gi     = cmd.step[0] ? i2_ff : i1_ff;
   assign gj     = cmd.step[1] ? j2_ff : j1_ff;
   assign gr_lin = 32'(gi) * 32'(MAX_Z_POINTS) + 32'(gj);

   always_ff @(posedge clock) begin
      if (x_we) x_mem[row32[XA-1:0]] <= req_ff.load_word;
      x_rd_ff <= x_mem[x_raddr];
   end
   always_ff @(posedge clock) begin
      if (z_we) z_mem[col32[ZA-1:0]] <= req_ff.load_word;
      z_rd_ff <= z_mem[z_raddr];
   end
   always_ff @(posedge clock) begin
      if (g_we) g_mem[gw_lin[GA-1:0]] <= req_ff.load_word;
      g_rd_ff <= g_mem[gr_lin[GA-1:0]];
   end

   // corner indices
   assign b_iz = first_ff;
   always_comb begin
      b_i1 = (ix_ff != '0) ? ix_ff - 1'b1 : '0;
      b_j1 = (b_iz != '0) ? b_iz - 1'b1 : '0;
      b_i2 = (b_i1 + 1'b1 < nx) ? b_i1 + 1'b1 : nx - 1'b1;
      b_j2 = (b_j1 + 1'b1 < nz) ? b_j1 + 1'b1 : nz - 1'b1;
   end

   assign st.is_query      = (req_ff.command == CMD_QUERY);
   assign st.search_empty  = (count_ff == '0);
   assign st.out_of_bounds = (ix_ff >= nx) || (b_iz >= nz);
   assign st.zero_spacing  = (x1_ff == x2_ff) || (z1_ff == z2_ff);

   // term operands
   always_comb begin
      dx    = cmd.term[0] ? {req_ff.query_x[W-1], req_ff.query_x} - {x1_ff[W-1], x1_ff}
                          : {x2_ff[W-1], x2_ff} - {req_ff.query_x[W-1], req_ff.query_x};
      dz    = cmd.term[1] ? {req_ff.query_z[W-1], req_ff.query_z} - {z1_ff[W-1], z1_ff}
                          : {z2_ff[W-1], z2_ff} - {req_ff.query_z[W-1], req_ff.query_z};
      cw    = {x2_ff[W-1], x2_ff} - {x1_ff[W-1], x1_ff};
      ch    = {z2_ff[W-1], z2_ff} - {z1_ff[W-1], z1_ff};
      mx    = dx[D-1] ? D'(-dx) : D'(dx);
      mz    = dz[D-1] ? D'(-dz) : D'(dz);
      mcw   = cw[D-1] ? D'(-cw) : D'(cw);
      mch   = ch[D-1] ? D'(-ch) : D'(ch);
      qsel  = gv_ff[cmd.term];
      mqsel = qsel[W-1] ? W'(-qsel) : W'(qsel);
      if (cmd.op == OP_CHECK) begin
         m1_a = mcw;
         m1_b = mch;
      end else begin
         m1_a = mx;
         m1_b = mz;
      end
      m1_out = m1_a * m1_b;
      m2_a   = (cmd.op == OP_TERM_HI) ? p_ff[P-1:D] : p_ff[D-1:0];
      m2_b   = mq_ff;
      m2_out = m2_a * m2_b;
      if (cmd.op == OP_TERM_HI) addend = NUM'(m2_out) << D;
      else                      addend = NUM'(m2_out);
   end

   assign step_m1 = cmd.step - 3'd1;
   assign num_mag = acc_ff[NUM-1] ? NUM'(-acc_ff) : NUM'(acc_ff);
   assign num_hi  = num_mag[NUM-1:D];
   assign rem_sh  = {rem_ff, num_lo_ff[D-1]};

   // saturation and sign of the quotient
   always_comb begin
      limit = (D'(1) << (W - 1)) - D'(!neg_ff);
      sat   = big_ff || (quo_ff > limit);
      qval  = sat ? limit : quo_ff;
      res   = neg_ff ? D'(-qval) : qval;
   end

   always_comb begin
      rsp_in              = '0;
      rsp_in.status       = cmd.emit_status;
      if (cmd.emit_status == STS_OK) begin
         rsp_in.interp_value = res[W-1:0];
         rsp_in.saturated    = sat;
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_ACCEPT: begin
            req_ff <= req_payload;
         end
         OP_SINIT: begin
            if (cmd.axis) ix_ff <= first_ff;
            first_ff <= '0;
            count_ff <= cmd.axis ? nz : nx;
         end
         OP_SREAD: begin
            it_ff <= it;
         end
         OP_SCMP: begin
            if ((cmd.axis ? z_rd_ff : x_rd_ff) <
                (cmd.axis ? req_ff.query_z : req_ff.query_x)) begin
               first_ff <= it_ff + 1'b1;
               count_ff <= count_ff - half - 1'b1;
            end else begin
               count_ff <= half;
            end
         end
         OP_BOUND: begin
            i1_ff <= b_i1;
            i2_ff <= b_i2;
            j1_ff <= b_j1;
            j2_ff <= b_j2;
         end
         OP_FETCH: begin
            if (cmd.step == 3'd1) begin
               x1_ff <= x_rd_ff;
               z1_ff <= z_rd_ff;
            end
            if (cmd.step == 3'd2) begin
               x2_ff <= x_rd_ff;
               z2_ff <= z_rd_ff;
            end
            if (cmd.step != 3'd0) gv_ff[step_m1[1:0]] <= g_rd_ff;
         end
         OP_CHECK: begin
            den_ff     <= m1_out;
            den_neg_ff <= cw[D-1] ^ ch[D-1];
            acc_ff     <= '0;
         end
         OP_TERM_P: begin
            p_ff        <= m1_out;
            mq_ff       <= mqsel;
            term_neg_ff <= dx[D-1] ^ dz[D-1] ^ qsel[W-1];
         end
         OP_TERM_LO, OP_TERM_HI: begin
            if (term_neg_ff) acc_ff <= acc_ff - $signed(addend);
            else             acc_ff <= acc_ff + $signed(addend);
         end
         OP_DIV_INIT: begin
            // a quotient of more than D bits saturates anyway
            big_ff    <= (num_hi >= {1'b0, den_ff});
            rem_ff    <= num_hi[P-1:0];
            num_lo_ff <= num_mag[D-1:0];
            quo_ff    <= '0;
            neg_ff    <= den_neg_ff ^ acc_ff[NUM-1];
         end
         OP_DIV_STEP: begin
            num_lo_ff <= num_lo_ff << 1;
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_ff <= P'(rem_sh - {1'b0, den_ff});
               quo_ff <= {quo_ff[D-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh[P-1:0];
               quo_ff <= {quo_ff[D-2:0], 1'b0};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
      if (cmd.emit) rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: design/rectilinear_bilinear_interpolator.sv
// Bilinear interpolator on a non-uniform rectilinear grid.
// Load request: busy in the decode state after accept, result strobe in the cycle after that.
// Query: busy through the two memory searches (at most log2(points) + 1 probes per axis),
// five corner reads, four blend terms and the 33-step divider, or until a bounds or spacing
// error ends it early; strobe follows, one at a time.
// Synchronous active-high reset clears control and point counts (256); memory stays
// undefined until loaded. Results cannot be stalled.
module rectilinear_bilinear_interpolator #(
   parameter int MAX_X_POINTS = rbi_pkg::DEF_MAX_X_POINTS,
   parameter int MAX_Z_POINTS = rbi_pkg::DEF_MAX_Z_POINTS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rbi_pkg::req_type req_payload,
   output logic             rsp_valid,
   output rbi_pkg::rsp_type rsp_payload,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import rbi_pkg::*;

   logic [8:0]    x_points_ff, z_points_ff;
   logic          csr_we;
   ctl_cmd_type   cmd;
   dp_status_type st;

   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_points_ff <= 9'd256;
         z_points_ff <= 9'd256;
      end else if (csr_we) begin
         if (csr_paddr[2] == REG_X_POINTS) x_points_ff <= csr_pwdata[8:0];
         if (csr_paddr[2] == REG_Z_POINTS) z_points_ff <= csr_pwdata[8:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_Z_POINTS) ? {23'd0, z_points_ff}
                                                      : {23'd0, x_points_ff};

   rbi_controller u_ctl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .st    (st)
   );

   rbi_datapath #(
      .MAX_X_POINTS (MAX_X_POINTS),
      .MAX_Z_POINTS (MAX_Z_POINTS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .x_points    (x_points_ff),
      .z_points    (z_points_ff),
      .cmd         (cmd),
      .st          (st),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: verif/rectilinear_bilinear_interpolator_tb.sv
// Testbench for the rectilinear bilinear interpolator: loads grids, sends queries
// and checks every result against a built-in predictor of the interpolation.
// Depends on rbi_pkg and the rectilinear_bilinear_interpolator top level.
module rectilinear_bilinear_interpolator_tb;
   import rbi_pkg::*;

   localparam int          CYCLE_LIMIT = 1000000;
   localparam int          NPTS        = 256;
   localparam logic signed [127:0] POS_LIM = 128'sh7FFF_FFFF;
   localparam logic signed [127:0] NEG_LIM = -128'sh8000_0000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_payload;
   logic        rsp_valid;
   rsp_type     rsp_payload;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   rectilinear_bilinear_interpolator u_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor state
   logic signed [31:0] x_grid [NPTS];
   logic signed [31:0] z_grid [NPTS];
   logic signed [31:0] cell_val [NPTS*NPTS];
   bit                 x_written [NPTS];
   bit                 z_written [NPTS];
   bit                 cell_written [NPTS*NPTS];
   logic [8:0]         x_count;
   logic [8:0]         z_count;

   rsp_type expected_rsp [$];
   int      mismatches;
   int      cycles;
   int      burst_left;
   int      status_seen [4];
   int      saturated_seen;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // compare each result strobe with the oldest expectation
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: %p", rsp_payload);
         end else begin
            exp_r = expected_rsp.pop_front();
            if (rsp_payload.interp_value !== exp_r.interp_value ||
                rsp_payload.status !== exp_r.status ||
                rsp_payload.saturated !== exp_r.saturated) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected value %0d status %0d sat %0d, got %0d %0d %0d",
                           exp_r.interp_value, exp_r.status, exp_r.saturated,
                           rsp_payload.interp_value, rsp_payload.status,
                           rsp_payload.saturated);
            end else begin
               status_seen[exp_r.status]++;
               if (exp_r.saturated)
                  saturated_seen++;
            end
         end
      end
   end

   function automatic int unsigned points_in_use(logic [8:0] cnt);
      return (cnt > NPTS) ? NPTS : cnt;
   endfunction

   // fixed halving lower-bound search; clean drops if an unloaded entry is read
   function automatic int unsigned lower_bound_idx(bit z_axis, int unsigned n,
                                                   logic signed [31:0] v, inout bit clean);
      int unsigned first, count, step, it;
      logic signed [31:0] c;
      first = 0;
      count = n;
      while (count > 0) begin
         step = count / 2;
         it   = first + step;
         c    = z_axis ? z_grid[it] : x_grid[it];
         if (!(z_axis ? z_written[it] : x_written[it]))
            clean = 1'b0;
         if (c < v) begin
            first = it + 1;
            count = count - step - 1;
         end else begin
            count = step;
         end
      end
      return first;
   endfunction

   // interpolate one query; clean reports whether every read entry was loaded
   function automatic rsp_type interpolate(logic signed [31:0] qx, logic signed [31:0] qz,
                                           output bit clean);
      rsp_type r;
      int unsigned nx, nz, ix, iz, i1, i2, j1, j2;
      logic signed [127:0] x1, x2, z1, z2, px, pz, num, den, quo;
      r = '{interp_value: '0, status: STS_BOUNDS, saturated: 1'b0};
      clean = 1'b1;
      nx = points_in_use(x_count);
      nz = points_in_use(z_count);
      ix = lower_bound_idx(1'b0, nx, qx, clean);
      iz = lower_bound_idx(1'b1, nz, qz, clean);
      if (ix >= nx || iz >= nz)
         return r;
      i1 = (ix > 0) ? ix - 1 : 0;
      j1 = (iz > 0) ? iz - 1 : 0;
      i2 = (i1 + 1 < nx) ? i1 + 1 : nx - 1;
      j2 = (j1 + 1 < nz) ? j1 + 1 : nz - 1;
      if (!(x_written[i1] && x_written[i2] && z_written[j1] && z_written[j2]))
         clean = 1'b0;
      x1 = x_grid[i1];
      x2 = x_grid[i2];
      z1 = z_grid[j1];
      z2 = z_grid[j2];
      px = qx;
      pz = qz;
      r.status = STS_SPACING;
      if (x2 == x1 || z2 == z1)
         return r;
      if (!(cell_written[i1*NPTS+j1] && cell_written[i2*NPTS+j1] &&
            cell_written[i1*NPTS+j2] && cell_written[i2*NPTS+j2]))
         clean = 1'b0;
      num = 128'(cell_val[i1*NPTS+j1]) * (x2 - px) * (z2 - pz)
          + 128'(cell_val[i2*NPTS+j1]) * (px - x1) * (z2 - pz)
          + 128'(cell_val[i1*NPTS+j2]) * (x2 - px) * (pz - z1)
          + 128'(cell_val[i2*NPTS+j2]) * (px - x1) * (pz - z1);
      den = (x2 - x1) * (z2 - z1);
      quo = num / den;
      r.status = STS_OK;
      if (quo > POS_LIM) begin
         quo = POS_LIM;
         r.saturated = 1'b1;
      end else if (quo < NEG_LIM) begin
         quo = NEG_LIM;
         r.saturated = 1'b1;
      end
      r.interp_value = quo[31:0];
      return r;
   endfunction

   function automatic rsp_type predict_and_apply(req_type q);
      rsp_type r;
      bit clean;
      r = '{interp_value: '0, status: STS_LOADED, saturated: 1'b0};
      case (q.command)
         CMD_LOAD_X: begin
            x_grid[q.row_index] = q.load_word;
            x_written[q.row_index] = 1'b1;
         end
         CMD_LOAD_Z: begin
            z_grid[q.column_index] = q.load_word;
            z_written[q.column_index] = 1'b1;
         end
         CMD_LOAD_GRID: begin
            cell_val[q.row_index*NPTS + q.column_index] = q.load_word;
            cell_written[q.row_index*NPTS + q.column_index] = 1'b1;
         end
         default: r = interpolate(q.query_x, q.query_z, clean);
      endcase
      return r;
   endfunction

   // send one request in bursts with random gaps
   task automatic send_request(req_type q);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      end
      burst_left--;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= q;
      do @(posedge clock); while (busy);
      expected_rsp.push_back(predict_and_apply(q));
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (expected_rsp.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic reg_sel, logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (reg_sel == REG_X_POINTS)
         x_count = value[8:0];
      else
         z_count = value[8:0];
   endtask

   task automatic set_counts(logic [8:0] nx, logic [8:0] nz);
      wait_idle();
      csr_write(REG_X_POINTS, {$urandom} & 32'hFFFF_FE00 | 32'(nx));
      csr_write(REG_Z_POINTS, 32'(nz));
   endtask

   task automatic load_word_at(logic [1:0] cmd, int unsigned row, int unsigned col,
                               logic [31:0] w);
      req_type q;
      q.command      = cmd;
      q.row_index    = 8'(row);
      q.column_index = 8'(col);
      q.load_word    = w;
      q.query_x      = $urandom;
      q.query_z      = $urandom;
      send_request(q);
   endtask

   task automatic query_at(logic [31:0] qx, logic [31:0] qz);
      req_type q;
      q.command      = CMD_QUERY;
      q.row_index    = 8'($urandom);
      q.column_index = 8'($urandom);
      q.load_word    = $urandom;
      q.query_x      = qx;
      q.query_z      = qz;
      send_request(q);
   endtask

   // pick a query coordinate near the loaded axis, sometimes anywhere
   function automatic logic [31:0] pick_coord(bit z_axis, int unsigned n);
      longint lo, hi, span, v;
      int unsigned k;
      if (n == 0 || $urandom_range(0, 4) == 0)
         return $urandom;
      lo = z_axis ? z_grid[0] : x_grid[0];
      hi = z_axis ? z_grid[n-1] : x_grid[n-1];
      if (hi < lo) begin
         v = lo; lo = hi; hi = v;
      end
      span = hi - lo + 4;
      k = $urandom_range(0, n - 1);
      if ($urandom_range(0, 3) == 0)
         v = longint'(z_axis ? z_grid[k] : x_grid[k]) + $signed($urandom_range(0, 6)) - 3;
      else
         v = lo - span / 4 + longint'({$urandom, $urandom} % (span + span / 2));
      if (v > 64'sh7FFF_FFFF)
         v = 64'sh7FFF_FFFF;
      if (v < -64'sh8000_0000)
         v = -64'sh8000_0000;
      return v[31:0];
   endfunction

   task automatic random_queries(int num);
      int unsigned nx, nz;
      logic [31:0] qx, qz;
      bit clean;
      rsp_type dummy;
      nx = points_in_use(x_count);
      nz = points_in_use(z_count);
      for (int i = 0; i < num; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            // drop a stray grid load somewhere else
            load_word_at(CMD_LOAD_GRID, $urandom_range(128, 255), $urandom, $urandom);
            continue;
         end
         clean = 1'b0;
         for (int t = 0; t < 40 && !clean; t++) begin
            qx = pick_coord(1'b0, nx);
            qz = pick_coord(1'b1, nz);
            dummy = interpolate(qx, qz, clean);
         end
         if (clean)
            query_at(qx, qz);
      end
   endtask

   // load sorted axes (with occasional repeats, or unsorted) and a grid block
   task automatic load_grid(int unsigned nx, int unsigned nz, int unsigned cells,
                            bit shuffled);
      longint c;
      for (int a = 0; a < 2; a++) begin
         c = -longint'($urandom_range(0, 32'h4000_0000));
         for (int i = 0; i < (a ? nz : nx); i++) begin
            load_word_at(a ? CMD_LOAD_Z : CMD_LOAD_X, i, i,
                         shuffled ? $urandom : c[31:0]);
            c += ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 32'h000F_FFFF);
         end
      end
      for (int i = 0; i < cells && i < nx; i++)
         for (int j = 0; j < cells && j < nz; j++)
            load_word_at(CMD_LOAD_GRID, i, j, $urandom);
   endtask

   task automatic test_directed();
      set_counts(9'd2, 9'd2);
      load_word_at(CMD_LOAD_X, 0, 0, 32'h8000_0000);
      load_word_at(CMD_LOAD_X, 1, 0, 32'h7FFF_FFFF);
      load_word_at(CMD_LOAD_Z, 0, 0, 32'h0000_0000);
      load_word_at(CMD_LOAD_Z, 0, 1, 32'h0000_0001);
      load_word_at(CMD_LOAD_GRID, 0, 0, 32'h7FFF_FFFF);
      load_word_at(CMD_LOAD_GRID, 0, 1, 32'h8000_0000);
      load_word_at(CMD_LOAD_GRID, 1, 0, 32'h0001_0000);
      load_word_at(CMD_LOAD_GRID, 1, 1, 32'hFFFF_0000);
      // loads beyond the used range are stored and still answer
      load_word_at(CMD_LOAD_GRID, 255, 255, 32'h1234_5678);
      query_at(32'h8000_0000, 32'h0000_0000);
      query_at(32'h7FFF_FFFF, 32'h0000_0001);
      query_at(32'h0000_0000, 32'h8000_0000);
      // extrapolation in z saturates at both ends of the x axis
      query_at(32'h8000_0000, 32'h8000_0000);
      query_at(32'h7FFF_FFFF, 32'h8000_0000);
      // beyond the grid on the z axis
      query_at(32'h0000_0000, 32'h0000_0002);
      query_at(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      // equal neighbors give zero spacing
      load_word_at(CMD_LOAD_Z, 0, 1, 32'h0000_0000);
      query_at(32'h0000_0000, 32'h0000_0000);
      // single point per axis
      set_counts(9'd1, 9'd1);
      query_at(32'h8000_0000, 32'h0000_0000);
      query_at(32'h8000_0001, 32'h0000_0000);
      // no points: everything is out of bounds
      set_counts(9'd0, 9'd0);
      query_at(32'h0000_0000, 32'h0000_0000);
      query_at(32'h8000_0000, 32'h8000_0000);
   endtask

   task automatic test_full_grid();
      set_counts(9'd256, 9'd256);
      load_grid(256, 256, 4, 1'b0);
      random_queries(120);
   endtask

   task automatic test_small_grids();
      load_grid(2, 2, 2, 1'b0);
      set_counts(9'd2, 9'd2);
      random_queries(70);
      set_counts(9'd3, 9'd5);
      load_grid(3, 5, 5, 1'b0);
      random_queries(100);
      set_counts(9'd8, 9'd8);
      load_grid(8, 8, 8, 1'b0);
      random_queries(150);
      set_counts(9'd1, 9'd6);
      random_queries(40);
   endtask

   task automatic test_unsorted();
      set_counts(9'd6, 9'd4);
      load_grid(6, 4, 6, 1'b1);
      random_queries(100);
   endtask

   task automatic test_clamped_counts();
      // counts above the store size clamp to it; x axis still loaded from before
      set_counts(9'd511, 9'd2);
      load_grid(2, 2, 2, 1'b0);
      random_queries(80);
      set_counts(9'd5, 9'd300);
      load_grid(5, 256, 5, 1'b0);
      random_queries(80);
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      burst_left  = 0;
      x_count     = 9'd256;
      z_count     = 9'd256;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_grid();
      test_small_grids();
      test_unsorted();
      test_clamped_counts();
      wait_idle();
      repeat (100) @(posedge clock);
      $display("Results checked: ok %0d, out of bounds %0d, zero spacing %0d, loads %0d",
               status_seen[STS_OK], status_seen[STS_BOUNDS], status_seen[STS_SPACING],
               status_seen[STS_LOADED]);
      $display("Saturated results %0d; pending expectations %0d",
               saturated_seen, expected_rsp.size());
      if (mismatches == 0 && expected_rsp.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
